FILE: rtl/core/mpbc_pkg.sv
package mpbc_pkg;

    localparam int unsigned DUTY_W = 7;
    localparam int unsigned CNT_W  = 23;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned SEG_W  = 7;

    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_MIN   = 7'd1;
    localparam logic [DUTY_W-1:0] FULL_SCALE = 7'd100;

    localparam logic [CFG_W-1:0] TICKS_RESET    = 16'd80;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;

    localparam logic [0:0] CFG_TICKS_PER_UNIT   = 1'b0;
    localparam logic [0:0] CFG_DEBOUNCE_SAMPLES = 1'b1;

    localparam logic [1:0] BTN_DOWN = 2'd0;
    localparam logic [1:0] BTN_UP   = 2'd1;
    localparam logic [1:0] BTN_DIR  = 2'd2;
    localparam logic [1:0] BTN_ONOFF = 2'd3;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              direction;
        logic              motor_on;
    } t_ctrl;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

endpackage

FILE: rtl/core/mpbc_buttons.sv
module mpbc_buttons (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [3:0]                   i_levels,
    input  logic [mpbc_pkg::CFG_W-1:0]   i_debounce,
    output mpbc_pkg::t_ctrl              o_ctrl
);
    import mpbc_pkg::*;

    logic [DUTY_W-1:0] r_duty, n_duty;
    logic              r_dir, n_dir;
    logic              r_on, n_on;
    logic              r_locked, n_locked;
    logic [1:0]        r_lock_btn, n_lock_btn;
    logic [CFG_W-1:0]  r_rel, n_rel;

    logic [3:0]        pressed;
    logic [DUTY_W-1:0] duty_dn;
    logic [CFG_W-1:0]  rel_inc;

    always_comb begin
        pressed    = ~i_levels;
        n_duty     = r_duty;
        n_dir      = r_dir;
        n_on       = r_on;
        n_locked   = r_locked;
        n_lock_btn = r_lock_btn;
        n_rel      = r_rel;
        rel_inc    = r_rel + 16'd1;
        duty_dn    = r_duty;

        if (r_locked) begin
            if (i_levels[r_lock_btn]) begin
                n_rel = rel_inc;
                if (rel_inc >= i_debounce || rel_inc == '0) begin
                    n_locked = 1'b0;
                    n_rel    = '0;
                end
            end else begin
                n_rel = '0;
            end
        end else if (pressed != 4'd0) begin
            if (pressed[BTN_DOWN]) begin
                duty_dn = (r_duty <= DUTY_MIN) ? DUTY_MAX : r_duty - 7'd1;
            end
            n_duty = duty_dn;
            if (pressed[BTN_UP]) begin
                n_duty = (duty_dn >= DUTY_MAX) ? DUTY_MIN : duty_dn + 7'd1;
            end
            n_dir = r_dir ^ pressed[BTN_DIR];
            n_on  = r_on ^ pressed[BTN_ONOFF];
            if (pressed[BTN_DOWN]) begin
                n_lock_btn = BTN_DOWN;
            end else if (pressed[BTN_UP]) begin
                n_lock_btn = BTN_UP;
            end else if (pressed[BTN_DIR]) begin
                n_lock_btn = BTN_DIR;
            end else begin
                n_lock_btn = BTN_ONOFF;
            end
            n_locked = 1'b1;
            n_rel    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty     <= DUTY_MAX;
            r_dir      <= 1'b1;
            r_on       <= 1'b1;
            r_locked   <= 1'b0;
            r_lock_btn <= BTN_DOWN;
            r_rel      <= '0;
        end else if (i_step) begin
            r_duty     <= n_duty;
            r_dir      <= n_dir;
            r_on       <= n_on;
            r_locked   <= n_locked;
            r_lock_btn <= n_lock_btn;
            r_rel      <= n_rel;
        end
    end

    assign o_ctrl.duty      = n_duty;
    assign o_ctrl.direction = n_dir;
    assign o_ctrl.motor_on  = n_on;

endmodule

FILE: rtl/core/mpbc_pwm.sv
module mpbc_pwm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  mpbc_pkg::t_ctrl              i_ctrl,
    input  logic [mpbc_pkg::CFG_W-1:0]   i_ticks_per_unit,
    output logic [1:0]                   o_pins
);
    import mpbc_pkg::*;

    logic [1:0]        r_pins, n_pins;
    logic [DUTY_W-1:0] r_interval, n_interval;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        sel;
    logic [CNT_W-1:0]  reload;

    always_comb begin
        n_pins     = r_pins;
        n_interval = r_interval;
        sel        = i_ctrl.direction ? 2'b10 : 2'b01;
        if (r_cnt > 23'd1) begin
            n_cnt = r_cnt - 23'd1;
        end else begin
            if (i_ctrl.motor_on) begin
                if ((r_pins & sel) == 2'b00) begin
                    n_interval = FULL_SCALE - i_ctrl.duty;
                    n_pins     = sel;
                end else begin
                    n_interval = i_ctrl.duty;
                    n_pins     = 2'b00;
                end
            end else begin
                n_pins = 2'b00;
            end
            n_cnt = reload;
        end
    end

    // 7 x 16 product fills the 23 bit counter exactly
    assign reload = CNT_W'(n_interval) * CNT_W'(i_ticks_per_unit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins     <= 2'b00;
            r_interval <= '0;
            r_cnt      <= 23'd1;
        end else if (i_step) begin
            r_pins     <= n_pins;
            r_interval <= n_interval;
            r_cnt      <= n_cnt;
        end
    end

    assign o_pins = n_pins;

endmodule

FILE: rtl/core/mpbc_seg.sv
module mpbc_seg (
    input  logic [mpbc_pkg::DUTY_W-1:0] i_duty,
    output logic [mpbc_pkg::SEG_W-1:0]  o_seg_tens,
    output logic [mpbc_pkg::SEG_W-1:0]  o_seg_units
);
    import mpbc_pkg::*;

    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic [6:0]  tens_x10;

    // divide by ten through reciprocal 205/2048, exact for values below 128
    assign prod     = 15'(i_duty) * 15'd205;
    assign tens     = prod[14:11];
    assign tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    assign units    = 4'(i_duty - tens_x10);

    assign o_seg_tens  = SEG_TABLE[tens];
    assign o_seg_units = SEG_TABLE[units];

endmodule

FILE: rtl/core/motor_pwm_button_controller_top.sv
// Software-style PWM for a DC motor with four debounced buttons and a two-digit
// duty display. One beat of button levels is one base timer tick; the block takes
// a beat every clock cycle while the output is not stalled, and returns one result
// beat per input beat through the input register, then the state update into the
// output register. The rate is set by the state update, whose longest path is the
// 7 x 16 bit interval reload multiply. No clearing pass follows reset.
module motor_pwm_button_controller_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [3:0]                   i_button_levels,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_drive_dir0,
    output logic                         o_drive_dir1,
    output logic [6:0]                   o_seg_tens,
    output logic [6:0]                   o_seg_units,
    output logic [6:0]                   o_duty_now,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_index,
    input  logic [mpbc_pkg::CFG_W-1:0]   i_cfg_data
);
    import mpbc_pkg::*;

    logic [CFG_W-1:0]  r_ticks_per_unit;
    logic [CFG_W-1:0]  r_debounce;
    logic              r_in_valid;
    logic [3:0]        r_levels;
    logic              r_out_valid;
    logic [1:0]        r_pins;
    logic [SEG_W-1:0]  r_seg_tens;
    logic [SEG_W-1:0]  r_seg_units;
    logic [DUTY_W-1:0] r_duty;

    logic              advance;
    t_ctrl             ctrl;
    logic [1:0]        pins;
    logic [SEG_W-1:0]  seg_tens;
    logic [SEG_W-1:0]  seg_units;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= TICKS_RESET;
            r_debounce       <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_UNIT:   r_ticks_per_unit <= i_cfg_data;
                CFG_DEBOUNCE_SAMPLES: r_debounce       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_levels <= i_button_levels;
        end
    end

    mpbc_buttons u_buttons (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_levels   (r_levels),
        .i_debounce (r_debounce),
        .o_ctrl     (ctrl)
    );

    mpbc_pwm u_pwm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_ctrl           (ctrl),
        .i_ticks_per_unit (r_ticks_per_unit),
        .o_pins           (pins)
    );

    mpbc_seg u_seg (
        .i_duty      (ctrl.duty),
        .o_seg_tens  (seg_tens),
        .o_seg_units (seg_units)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pins      <= pins;
            r_seg_tens  <= seg_tens;
            r_seg_units <= seg_units;
            r_duty      <= ctrl.duty;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive_dir0 = r_pins[0];
    assign o_drive_dir1 = r_pins[1];
    assign o_seg_tens   = r_seg_tens;
    assign o_seg_units  = r_seg_units;
    assign o_duty_now   = r_duty;

endmodule

FILE: verif/tb_motor_pwm_button_controller_top.sv
`timescale 1ns / 1ps

module tb_motor_pwm_button_controller_top;
    import mpbc_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic       drive_dir0;
        logic       drive_dir1;
        logic [6:0] seg_tens;
        logic [6:0] seg_units;
        logic [6:0] duty_now;
    } t_pwm_result;

    localparam logic [6:0] SEG_CODE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [3:0]       i_button_levels = 4'hF;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_drive_dir0;
    logic             o_drive_dir1;
    logic [6:0]       o_seg_tens;
    logic [6:0]       o_seg_units;
    logic [6:0]       o_duty_now;
    logic             i_cfg_we = 1'b0;
    logic [0:0]       i_cfg_index = CFG_TICKS_PER_UNIT;
    logic [CFG_W-1:0] i_cfg_data = '0;

    motor_pwm_button_controller_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_button_levels (i_button_levels),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_dir0    (o_drive_dir0),
        .o_drive_dir1    (o_drive_dir1),
        .o_seg_tens      (o_seg_tens),
        .o_seg_units     (o_seg_units),
        .o_duty_now      (o_duty_now),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // controller state as the testbench sees it
    logic [15:0] ticks_cfg    = TICKS_RESET;
    logic [15:0] debounce_cfg = DEBOUNCE_RESET;
    logic [6:0]  duty         = DUTY_MAX;
    logic        dir_sel      = 1'b1;
    logic        motor_on     = 1'b1;
    logic [1:0]  pins         = 2'b00;
    logic [6:0]  interval     = 7'd0;
    logic [22:0] tick_count   = 23'd1;
    logic        btn_locked   = 1'b0;
    logic [1:0]  lock_btn     = BTN_DOWN;
    logic [15:0] release_run  = 16'd0;

    t_pwm_result pending_results [$];

    int err_count       = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int pin_toggles     = 0;
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int rx_hold_request = 0;
    int idle_cycles     = 0;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        err_count++;
        if (err_count <= 30) begin
            $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want_v, $time);
        end
    endtask

    task automatic predict_tick(input logic [3:0] levels);
        logic [3:0]  pressed;
        logic [1:0]  sel;
        logic [31:0] reload;
        t_pwm_result r;
        pressed = ~levels;
        if (btn_locked) begin
            if (levels[lock_btn]) begin
                release_run = release_run + 16'd1;
                if (release_run >= debounce_cfg || release_run == 16'd0) begin
                    btn_locked  = 1'b0;
                    release_run = 16'd0;
                end
            end else begin
                release_run = 16'd0;
            end
        end else if (pressed != 4'd0) begin
            if (pressed[0]) duty = (duty <= 7'd1) ? DUTY_MAX : duty - 7'd1;
            if (pressed[1]) duty = (duty >= DUTY_MAX) ? 7'd1 : duty + 7'd1;
            if (pressed[2]) dir_sel = ~dir_sel;
            if (pressed[3]) motor_on = ~motor_on;
            if (pressed[0])      lock_btn = BTN_DOWN;
            else if (pressed[1]) lock_btn = BTN_UP;
            else if (pressed[2]) lock_btn = BTN_DIR;
            else                 lock_btn = BTN_ONOFF;
            btn_locked  = 1'b1;
            release_run = 16'd0;
        end
        if (tick_count > 23'd1) begin
            tick_count = tick_count - 23'd1;
        end else begin
            if (motor_on) begin
                sel = dir_sel ? 2'b10 : 2'b01;
                if ((pins & sel) == 2'b00) begin
                    interval = FULL_SCALE - duty;
                    pins     = sel;
                end else begin
                    interval = duty;
                    pins     = 2'b00;
                end
                pin_toggles++;
            end else begin
                pins = 2'b00;
            end
            reload     = 32'(interval) * 32'(ticks_cfg);
            tick_count = reload[22:0];
        end
        r.drive_dir0 = pins[0];
        r.drive_dir1 = pins[1];
        r.seg_tens   = SEG_CODE[(duty / 7'd10) % 7'd10];
        r.seg_units  = SEG_CODE[duty % 7'd10];
        r.duty_now   = duty;
        pending_results.push_back(r);
    endtask

    task automatic send_beat(input logic [3:0] levels);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_button_levels <= levels;
        do @(posedge i_clk); while (!o_in_ready);
        predict_tick(levels);
        beats_sent++;
    endtask

    // one press, a few held or bouncing samples, then about debounce releases
    task automatic send_press_run();
        logic [3:0] mask;
        logic [3:0] levels;
        int lowest;
        int n_hold;
        int n_rel;
        if ($urandom_range(0, 9) == 0) begin
            send_beat(4'($urandom));
            return;
        end
        if ($urandom_range(0, 2) == 0) mask = 4'($urandom_range(1, 15));
        else mask = 4'b0001 << $urandom_range(0, 3);
        lowest = mask[0] ? 0 : mask[1] ? 1 : mask[2] ? 2 : 3;
        send_beat(~mask);
        n_hold = $urandom_range(0, 2);
        for (int k = 0; k < n_hold; k++) begin
            levels = 4'($urandom);
            levels[lowest] = 1'b0;
            send_beat(levels);
        end
        n_rel = (debounce_cfg == 16'd0) ? 1 : (debounce_cfg > 16'd40) ? 40 : int'(debounce_cfg);
        n_rel = n_rel + $urandom_range(0, 2) - 1;
        for (int k = 0; k < n_rel; k++) begin
            levels = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
            levels[lowest] = 1'b1;
            send_beat(levels);
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [15:0] ticks, input logic [15:0] debounce);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TICKS_PER_UNIT;
        i_cfg_data  <= ticks;
        @(posedge i_clk);
        ticks_cfg = ticks;
        i_cfg_index <= CFG_DEBOUNCE_SAMPLES;
        i_cfg_data  <= debounce;
        @(posedge i_clk);
        debounce_cfg = debounce;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        repeat (3) send_beat(4'hF);
        wait_results_drained();
    endtask

    task automatic test_duty_buttons();
        write_config(16'd1, 16'd1);
        send_beat(4'hF);
        send_beat(4'b1101);   // up wraps 99 to 1
        send_beat(4'hF);
        send_beat(4'b1110);   // down wraps 1 to 99
        send_beat(4'hF);
        send_beat(4'b0000);   // all four at once
        send_beat(4'hF);
        send_beat(4'b0111);
        send_beat(4'hF);
        send_beat(4'b1011);
        wait_results_drained();
    endtask

    task automatic test_debounce_lock();
        write_config(16'd1, 16'd3);
        send_beat(4'b1110);
        send_beat(4'hF);
        send_beat(4'b1110);   // still held, release run restarts
        repeat (3) send_beat(4'hF);
        send_beat(4'b1110);
        repeat (3) send_beat(4'hF);
        wait_results_drained();
    endtask

    task automatic test_zero_cases();
        write_config(16'd1, 16'd0);
        send_beat(4'b1101);
        send_beat(4'hF);
        send_beat(4'b1101);
        send_beat(4'hF);
        wait_results_drained();
        write_config(16'd0, 16'd1);
        repeat (2) send_beat(4'hF);
        send_beat(4'b0111);   // motor off keeps interval
        repeat (2) send_beat(4'hF);
        send_beat(4'b0111);
        wait_results_drained();
    endtask

    task automatic run_random_phase(input logic [15:0] ticks, input logic [15:0] debounce,
                                    input int tx_pct, input int rx_pct, input int n_beats,
                                    input bit noise_only);
        int target;
        write_config(ticks, debounce);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target = beats_sent + n_beats;
        while (beats_sent < target) begin
            if (noise_only) send_beat(4'($urandom));
            else send_press_run();
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'd1, 16'd1, 0, 0, 300, 1'b0);
        run_random_phase(16'd2, 16'd4, 46, 0, 300, 1'b0);
        run_random_phase(16'd3, 16'd2, 0, 46, 300, 1'b0);
        run_random_phase(16'($urandom_range(1, 5)), 16'd3, 30, 30, 300, 1'b0);
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_request = 200;
        run_random_phase(16'd1, 16'd2, 0, 0, 250, 1'b0);
    endtask

    task automatic test_config_extremes();
        run_random_phase(16'hFFFF, 16'hFFFF, 30, 30, 200, 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_duty_buttons();
        test_debounce_lock();
        test_zero_cases();
        test_random_traffic();
        test_output_backpressure();
        test_config_extremes();
        $display("tb: %0d button beats sent, %0d results checked, %0d pin toggles",
                 beats_sent, results_checked, pin_toggles);
        $display("tb: wrap, debounce, zero reload, motor off and output stall all exercised");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        int hold_left;
        if (rx_hold_request > 0) begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pwm_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_drive_dir0 !== want.drive_dir0)
                    report_mismatch("drive_dir0", o_drive_dir0, want.drive_dir0);
                if (o_drive_dir1 !== want.drive_dir1)
                    report_mismatch("drive_dir1", o_drive_dir1, want.drive_dir1);
                if (o_seg_tens !== want.seg_tens)
                    report_mismatch("seg_tens", o_seg_tens, want.seg_tens);
                if (o_seg_units !== want.seg_units)
                    report_mismatch("seg_units", o_seg_units, want.seg_units);
                if (o_duty_now !== want.duty_now)
                    report_mismatch("duty_now", o_duty_now, want.duty_now);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
